>>> hdl/lrc_pkg.sv
// ----------------------------------------------------------------------------
// lrc_pkg
// shared types and codes of the line to rectangle clipper
// ----------------------------------------------------------------------------
`default_nettype none

package lrc_pkg;

    localparam int CFG_INDEX_BITS = 2;
    localparam int NUM_EDGES      = 4;

    // configuration register map
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_CENTER_X    = 2'd0,
        REG_CENTER_Y    = 2'd1,
        REG_RECT_WIDTH  = 2'd2,
        REG_RECT_HEIGHT = 2'd3
    } cfg_reg_t;

    // edges in the order they are handled
    typedef enum logic [1:0] {
        EDGE_LEFT   = 2'd0,
        EDGE_RIGHT  = 2'd1,
        EDGE_TOP    = 2'd2,
        EDGE_BOTTOM = 2'd3
    } edge_id_t;

    // sign flags of one edge's p and q terms
    typedef struct packed {
        logic pz;     // p is zero
        logic pneg;   // p below zero
        logic qneg;   // q below zero
        logic rneg;   // ratio q/p below zero
        logic rzero;  // q is zero
    } edge_ctl_t;

    // running clip decision
    typedef struct packed {
        logic     ok;
        logic     in_upd;
        edge_id_t in_edge;
        logic     out_upd;
        edge_id_t out_edge;
    } clip_sel_t;

endpackage

`default_nettype wire

>>> hdl/line_rect_clipper_core.sv
// ----------------------------------------------------------------------------
// line_rect_clipper_core
// liang-barsky clipping of one segment against a center/size rectangle
// ----------------------------------------------------------------------------
//  channel   ports            item
//  --------  ---------------  ----------------------------------------------
//  input     s_tvalid/tready  s_tdata: start_x, start_y, end_x, end_y
//  result    m_tvalid/tready  m_tdata: clipped points, t_enter, t_exit
//                             m_tuser: accepted
//  config    cfg_wr_en        cfg_index selects the register, cfg_wdata value
//
//  one item per cycle while the skid stage is empty; the ratio dividers give
//  one bit per stage (T_FRAC_BITS + 1 stages)
//  reset clears valid bits and the rectangle registers, nothing else
//  a stalled result sits in the output register, a second in the skid stage;
//  the pipeline holds only once the skid stage is full
// ----------------------------------------------------------------------------
`default_nettype none

module line_rect_clipper_core #(
    parameter int COORD_BITS  = 16,
    parameter int T_FRAC_BITS = 16
) (
    input  wire logic aclk,
    input  wire logic aresetn,

    // start_x, start_y, end_x, end_y from the lowest bit up, zero padded
    input  wire logic [((4*COORD_BITS)+7)/8*8-1:0] s_tdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,

    // clip_start_x, clip_start_y, clip_end_x, clip_end_y, t_enter, t_exit
    output logic [((4*COORD_BITS+2*(T_FRAC_BITS+1))+7)/8*8-1:0] m_tdata,
    // accepted
    output logic                                   m_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,

    input  wire logic                              cfg_wr_en,
    input  wire logic [lrc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [COORD_BITS-1:0]             cfg_wdata
);

    localparam int C        = COORD_BITS;
    localparam int F        = T_FRAC_BITS;
    localparam int OUT_W    = ((4*C + 2*(F+1)) + 7) / 8 * 8;
    localparam int FIELDS_W = 4*C + 2*(F+1);
    localparam int GEO_W    = 2*C + 2*(C+1) + 4*(C+2);
    localparam int CTL_W    = lrc_pkg::NUM_EDGES * $bits(lrc_pkg::edge_ctl_t) + 1;
    // offsets in the geometry vector
    localparam int O_DX     = 2*C;
    localparam int O_DY     = 3*C + 1;
    localparam int O_EDGE   = 4*C + 2;

    // ---------------- configuration registers ----------------
    logic signed [C-1:0] center_x_reg, center_y_reg;
    logic        [C-1:0] rect_width_reg, rect_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg    <= '0;
            center_y_reg    <= '0;
            rect_width_reg  <= '0;
            rect_height_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (lrc_pkg::cfg_reg_t'(cfg_index))
                lrc_pkg::REG_CENTER_X:    center_x_reg    <= cfg_wdata;
                lrc_pkg::REG_CENTER_Y:    center_y_reg    <= cfg_wdata;
                lrc_pkg::REG_RECT_WIDTH:  rect_width_reg  <= cfg_wdata;
                lrc_pkg::REG_RECT_HEIGHT: rect_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- pipeline advance ----------------
    // the whole pipeline moves while the skid stage is empty
    logic skid_valid_reg;
    logic en;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // ---------------- setup: edges, p/q terms ----------------
    logic                     st_valid;
    logic signed [C-1:0]      st_sx, st_sy;
    logic signed [C:0]        st_dx, st_dy;
    logic signed [C+1:0]      st_edge [4];
    logic                     st_glide;
    lrc_pkg::edge_ctl_t [3:0] st_ctl;
    logic [C+1:0]             st_num [4];
    logic [C+1:0]             st_den_x, st_den_y;

    lrc_setup #(
        .COORD_BITS (C)
    ) u_setup (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (s_tvalid),
        .start_x     (s_tdata[C-1:0]),
        .start_y     (s_tdata[2*C-1:C]),
        .end_x       (s_tdata[3*C-1:2*C]),
        .end_y       (s_tdata[4*C-1:3*C]),
        .center_x    (center_x_reg),
        .center_y    (center_y_reg),
        .rect_width  (rect_width_reg),
        .rect_height (rect_height_reg),
        .out_valid   (st_valid),
        .sx          (st_sx),
        .sy          (st_sy),
        .dx          (st_dx),
        .dy          (st_dy),
        .edge_pos    (st_edge),
        .glide_rej   (st_glide),
        .ctl         (st_ctl),
        .num         (st_num),
        .den_x       (st_den_x),
        .den_y       (st_den_y)
    );

    // ---------------- ratio dividers, one per edge ----------------
    logic [F:0] dv_quo [4];
    logic       dv_sat [4];

    for (genvar i = 0; i < 4; i++) begin : g_div
        lrc_div #(
            .COORD_BITS  (C),
            .T_FRAC_BITS (F)
        ) u_div (
            .aclk (aclk),
            .en   (en),
            .num  (st_num[i]),
            .den  ((i < 2) ? st_den_x : st_den_y),
            .quo  (dv_quo[i]),
            .sat  (dv_sat[i])
        );
    end

    // side data waits beside the dividers
    logic [GEO_W+CTL_W-1:0] dl_in, dl_out;
    logic                   dl_valid;

    assign dl_in = {st_edge[3], st_edge[2], st_edge[1], st_edge[0],
                    st_dy, st_dx, st_sy, st_sx, st_ctl, st_glide};

    lrc_delay #(
        .WIDTH (GEO_W + CTL_W),
        .DEPTH (F + 1)
    ) u_delay (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (st_valid),
        .in_data   (dl_in),
        .out_valid (dl_valid),
        .out_data  (dl_out)
    );

    // ---------------- interval selection over the edges ----------------
    lrc_pkg::edge_ctl_t [3:0] dl_ctl;
    logic                     sl_valid;
    lrc_pkg::clip_sel_t       sl_sel;
    logic [F:0]               sl_tin, sl_tout;
    logic [GEO_W-1:0]         sl_geo;

    assign dl_ctl = dl_out[CTL_W-1:1];

    lrc_select #(
        .T_FRAC_BITS (F),
        .GEO_W       (GEO_W)
    ) u_select (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (dl_valid),
        .ctl       (dl_ctl),
        .glide_rej (dl_out[0]),
        .quo       (dv_quo),
        .sat       (dv_sat),
        .in_geo    (dl_out[GEO_W+CTL_W-1:CTL_W]),
        .out_valid (sl_valid),
        .out_sel   (sl_sel),
        .t_in      (sl_tin),
        .t_out     (sl_tout),
        .out_geo   (sl_geo)
    );

    logic signed [C+1:0] sl_edge [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            sl_edge[i] = sl_geo[O_EDGE + i*(C+2) +: C+2];
        end
    end

    // ---------------- clipped endpoints ----------------
    logic         pp_valid, pp_acc;
    logic [C-1:0] pp_sx, pp_sy, pp_ex, pp_ey;
    logic [F:0]   pp_tin, pp_tout;

    lrc_point #(
        .COORD_BITS  (C),
        .T_FRAC_BITS (F)
    ) u_point (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .in_valid     (sl_valid),
        .sel          (sl_sel),
        .t_in         (sl_tin),
        .t_out        (sl_tout),
        .sx           (sl_geo[C-1:0]),
        .sy           (sl_geo[2*C-1:C]),
        .dx           (sl_geo[O_DX +: C+1]),
        .dy           (sl_geo[O_DY +: C+1]),
        .edge_pos     (sl_edge),
        .out_valid    (pp_valid),
        .accepted     (pp_acc),
        .clip_start_x (pp_sx),
        .clip_start_y (pp_sy),
        .clip_end_x   (pp_ex),
        .clip_end_y   (pp_ey),
        .t_enter      (pp_tin),
        .t_exit       (pp_tout)
    );

    // ---------------- output register and skid stage ----------------
    logic [OUT_W-1:0] pp_data;
    logic [OUT_W-1:0] m_data_reg, skid_data_reg;
    logic             m_user_reg, skid_user_reg;
    logic             m_tvalid_reg;

    always_comb begin
        pp_data = '0;
        pp_data[FIELDS_W-1:0] = {pp_tout, pp_tin, pp_ey, pp_ex, pp_sy, pp_sx};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg   <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            // pipeline held; drain the skid item first
            if (m_tready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (!m_tvalid_reg || m_tready) begin
            m_tvalid_reg <= pp_valid;
        end else if (pp_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_tready) begin
                m_data_reg <= skid_data_reg;
                m_user_reg <= skid_user_reg;
            end
        end else if (!m_tvalid_reg || m_tready) begin
            m_data_reg <= pp_data;
            m_user_reg <= pp_acc;
        end else begin
            skid_data_reg <= pp_data;
            skid_user_reg <= pp_acc;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

`default_nettype wire

>>> hdl/lrc_setup.sv
// ----------------------------------------------------------------------------
// lrc_setup
// two stages: edges and deltas, then p/q terms, magnitudes and glide test
// ----------------------------------------------------------------------------
`default_nettype none

module lrc_setup #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         en,
    input  wire logic                         in_valid,
    input  wire logic signed [COORD_BITS-1:0] start_x,
    input  wire logic signed [COORD_BITS-1:0] start_y,
    input  wire logic signed [COORD_BITS-1:0] end_x,
    input  wire logic signed [COORD_BITS-1:0] end_y,
    input  wire logic signed [COORD_BITS-1:0] center_x,
    input  wire logic signed [COORD_BITS-1:0] center_y,
    input  wire logic        [COORD_BITS-1:0] rect_width,
    input  wire logic        [COORD_BITS-1:0] rect_height,
    output logic                              out_valid,
    output logic signed [COORD_BITS-1:0]      sx,
    output logic signed [COORD_BITS-1:0]      sy,
    output logic signed [COORD_BITS:0]        dx,
    output logic signed [COORD_BITS:0]        dy,
    output logic signed [COORD_BITS+1:0]      edge_pos [4],
    output logic                              glide_rej,
    output lrc_pkg::edge_ctl_t [3:0]          ctl,
    output logic        [COORD_BITS+1:0]      num [4],
    output logic        [COORD_BITS+1:0]      den_x,
    output logic        [COORD_BITS+1:0]      den_y
);

    localparam int C = COORD_BITS;

    // stage a
    logic                a_valid_reg;
    logic signed [C-1:0] a_sx_reg, a_sy_reg;
    logic signed [C:0]   a_dx_reg, a_dy_reg;
    logic signed [C+1:0] a_edge_reg [4];
    logic signed [C+1:0] a_edge_next [4];
    logic signed [C+1:0] cx2, cy2, w_ext, h_ext;

    // stage b
    logic                b_valid_reg;
    logic signed [C-1:0] b_sx_reg, b_sy_reg;
    logic signed [C:0]   b_dx_reg, b_dy_reg;
    logic signed [C+1:0] b_edge_reg [4];
    logic                b_glide_reg;
    lrc_pkg::edge_ctl_t [3:0] b_ctl_reg, b_ctl_next;
    logic [C+1:0]        b_num_reg [4];
    logic [C+1:0]        b_num_next [4];
    logic [C+1:0]        b_denx_reg, b_deny_reg, b_denx_next, b_deny_next;
    logic                b_glide_next;

    logic signed [C+1:0] sx2, sy2;
    logic signed [C+2:0] q [4];
    logic        [C+2:0] q_abs [4];
    logic signed [C:0]   dx_abs, dy_abs;
    logic                pneg [4];

    always_comb begin
        cx2   = {center_x[C-1], center_x, 1'b0};
        cy2   = {center_y[C-1], center_y, 1'b0};
        w_ext = {2'b00, rect_width};
        h_ext = {2'b00, rect_height};
        a_edge_next[0] = cx2 - w_ext;
        a_edge_next[1] = cx2 + w_ext;
        a_edge_next[2] = cy2 - h_ext;
        a_edge_next[3] = cy2 + h_ext;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_sx_reg <= start_x;
            a_sy_reg <= start_y;
            a_dx_reg <= {end_x[C-1], end_x} - {start_x[C-1], start_x};
            a_dy_reg <= {end_y[C-1], end_y} - {start_y[C-1], start_y};
            for (int i = 0; i < 4; i++) begin
                a_edge_reg[i] <= a_edge_next[i];
            end
        end
    end

    always_comb begin
        sx2  = {a_sx_reg[C-1], a_sx_reg, 1'b0};
        sy2  = {a_sy_reg[C-1], a_sy_reg, 1'b0};
        q[0] = {sx2[C+1], sx2} - {a_edge_reg[0][C+1], a_edge_reg[0]};
        q[1] = {a_edge_reg[1][C+1], a_edge_reg[1]} - {sx2[C+1], sx2};
        q[2] = {sy2[C+1], sy2} - {a_edge_reg[2][C+1], a_edge_reg[2]};
        q[3] = {a_edge_reg[3][C+1], a_edge_reg[3]} - {sy2[C+1], sy2};
        pneg[0] = a_dx_reg > 0;
        pneg[1] = a_dx_reg < 0;
        pneg[2] = a_dy_reg > 0;
        pneg[3] = a_dy_reg < 0;
        for (int i = 0; i < 4; i++) begin
            q_abs[i]            = q[i][C+2] ? (~q[i] + 1'b1) : q[i];
            b_num_next[i]       = q_abs[i][C+1:0];
            b_ctl_next[i].pz    = (i < 2) ? (a_dx_reg == 0) : (a_dy_reg == 0);
            b_ctl_next[i].pneg  = pneg[i];
            b_ctl_next[i].qneg  = q[i][C+2];
            b_ctl_next[i].rzero = (q[i] == 0);
            b_ctl_next[i].rneg  = (q[i] != 0) && (q[i][C+2] != pneg[i]);
        end
        dx_abs      = a_dx_reg[C] ? -a_dx_reg : a_dx_reg;
        dy_abs      = a_dy_reg[C] ? -a_dy_reg : a_dy_reg;
        b_denx_next = {1'b0, dx_abs[C-1:0], 1'b0};
        b_deny_next = {1'b0, dy_abs[C-1:0], 1'b0};
        // a segment gliding along an edge is rejected
        if (a_dx_reg == 0) begin
            b_glide_next = (sx2 == a_edge_reg[0]) || (sx2 == a_edge_reg[1]);
        end else if (a_dy_reg == 0) begin
            b_glide_next = (sy2 == a_edge_reg[2]) || (sy2 == a_edge_reg[3]);
        end else begin
            b_glide_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (en) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_sx_reg    <= a_sx_reg;
            b_sy_reg    <= a_sy_reg;
            b_dx_reg    <= a_dx_reg;
            b_dy_reg    <= a_dy_reg;
            b_glide_reg <= b_glide_next;
            b_ctl_reg   <= b_ctl_next;
            b_denx_reg  <= b_denx_next;
            b_deny_reg  <= b_deny_next;
            for (int i = 0; i < 4; i++) begin
                b_edge_reg[i] <= a_edge_reg[i];
                b_num_reg[i]  <= b_num_next[i];
            end
        end
    end

    always_comb begin
        out_valid = b_valid_reg;
        sx        = b_sx_reg;
        sy        = b_sy_reg;
        dx        = b_dx_reg;
        dy        = b_dy_reg;
        glide_rej = b_glide_reg;
        ctl       = b_ctl_reg;
        den_x     = b_denx_reg;
        den_y     = b_deny_reg;
        for (int i = 0; i < 4; i++) begin
            edge_pos[i] = b_edge_reg[i];
            num[i]      = b_num_reg[i];
        end
    end

endmodule

`default_nettype wire

>>> hdl/lrc_div.sv
// ----------------------------------------------------------------------------
// lrc_div
// pipelined restoring divider, one quotient bit per stage, with overflow flag
// ----------------------------------------------------------------------------
`default_nettype none

module lrc_div #(
    parameter int COORD_BITS  = 16,
    parameter int T_FRAC_BITS = 16
) (
    input  wire logic                    aclk,
    input  wire logic                    en,
    input  wire logic [COORD_BITS+1:0]   num,
    input  wire logic [COORD_BITS+1:0]   den,
    output logic      [T_FRAC_BITS:0]    quo,
    output logic                         sat
);

    localparam int C = COORD_BITS;
    localparam int F = T_FRAC_BITS;

    logic [C+1:0] r_reg   [F+1];
    logic [C+1:0] den_reg [F+1];
    logic [F:0]   q_reg   [F+1];
    logic         sat_reg [F+1];

    logic         b0;
    logic [C+1:0] r0;

    // first stage: integer bit and overflow (ratio two or more)
    always_comb begin
        b0 = num >= den;
        r0 = b0 ? (num - den) : num;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0]   <= r0;
            den_reg[0] <= den;
            q_reg[0]   <= {{F{1'b0}}, b0};
            sat_reg[0] <= {1'b0, num} >= {den, 1'b0};
        end
    end

    for (genvar k = 1; k <= F; k++) begin : g_step
        logic [C+1:0] r2;
        logic         b;
        always_comb begin
            r2 = {r_reg[k-1][C:0], 1'b0};
            b  = r2 >= den_reg[k-1];
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[k]   <= b ? (r2 - den_reg[k-1]) : r2;
                den_reg[k] <= den_reg[k-1];
                q_reg[k]   <= {q_reg[k-1][F-1:0], b};
                sat_reg[k] <= sat_reg[k-1];
            end
        end
    end

    assign quo = q_reg[F];
    assign sat = sat_reg[F];

endmodule

`default_nettype wire

>>> hdl/lrc_delay.sv
// ----------------------------------------------------------------------------
// lrc_delay
// stallable delay line with valid, keeps side data beside the divider
// ----------------------------------------------------------------------------
`default_nettype none

module lrc_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             en,
    input  wire logic             in_valid,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    output logic      [WIDTH-1:0] out_data
);

    logic             valid_reg [DEPTH];
    logic [WIDTH-1:0] data_reg  [DEPTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else if (en) begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < DEPTH; i++) begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg[0] <= in_data;
            for (int i = 1; i < DEPTH; i++) begin
                data_reg[i] <= data_reg[i-1];
            end
        end
    end

    assign out_valid = valid_reg[DEPTH-1];
    assign out_data  = data_reg[DEPTH-1];

endmodule

`default_nettype wire

>>> hdl/lrc_select.sv
// ----------------------------------------------------------------------------
// lrc_select
// ratio coding, then one stage per edge narrowing the entry/exit interval
// ----------------------------------------------------------------------------
`default_nettype none

module lrc_select #(
    parameter int T_FRAC_BITS = 16,
    parameter int GEO_W       = 8
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     en,
    input  wire logic                     in_valid,
    input  wire lrc_pkg::edge_ctl_t [3:0] ctl,
    input  wire logic                     glide_rej,
    input  wire logic [T_FRAC_BITS:0]     quo [4],
    input  wire logic                     sat [4],
    input  wire logic [GEO_W-1:0]         in_geo,
    output logic                          out_valid,
    output lrc_pkg::clip_sel_t            out_sel,
    output logic [T_FRAC_BITS:0]          t_in,
    output logic [T_FRAC_BITS:0]          t_out,
    output logic [GEO_W-1:0]              out_geo
);

    localparam int F = T_FRAC_BITS;
    localparam logic signed [F+2:0] T_ONE   = {2'b00, 1'b1, {F{1'b0}}};
    localparam logic signed [F+2:0] T_OVER  = T_ONE + 1'b1;
    localparam logic signed [F+2:0] T_BELOW = '1;

    logic                     valid_reg [5];
    lrc_pkg::clip_sel_t       sel_reg   [5];
    logic [F:0]               tin_reg   [5];
    logic [F:0]               tout_reg  [5];
    logic [GEO_W-1:0]         geo_reg   [5];
    logic signed [F+2:0]      code_reg  [4][4];
    lrc_pkg::edge_ctl_t [3:0] ctl_reg   [4];

    logic signed [F+2:0]      code_next [4];
    lrc_pkg::clip_sel_t       sel_init;

    // ratio codes: zero, below zero, truncated value, or past one
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (ctl[i].rzero) begin
                code_next[i] = '0;
            end else if (ctl[i].rneg) begin
                code_next[i] = T_BELOW;
            end else if (sat[i] || ({2'b00, quo[i]} > T_ONE)) begin
                code_next[i] = T_OVER;
            end else begin
                code_next[i] = {2'b00, quo[i]};
            end
        end
        sel_init          = '0;
        sel_init.ok       = !glide_rej;
        sel_init.in_edge  = lrc_pkg::EDGE_LEFT;
        sel_init.out_edge = lrc_pkg::EDGE_LEFT;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < 5; s++) begin
                valid_reg[s] <= 1'b0;
            end
        end else if (en) begin
            valid_reg[0] <= in_valid;
            for (int s = 1; s < 5; s++) begin
                valid_reg[s] <= valid_reg[s-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sel_reg[0]  <= sel_init;
            tin_reg[0]  <= '0;
            tout_reg[0] <= T_ONE[F:0];
            geo_reg[0]  <= in_geo;
            ctl_reg[0]  <= ctl;
            for (int i = 0; i < 4; i++) begin
                code_reg[0][i] <= code_next[i];
            end
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_edge
        lrc_pkg::clip_sel_t  sel_n;
        logic [F:0]          tin_n, tout_n;
        logic signed [F+2:0] r, tin_s, tout_s;

        always_comb begin
            sel_n  = sel_reg[g];
            tin_n  = tin_reg[g];
            tout_n = tout_reg[g];
            r      = code_reg[g][g];
            tin_s  = {2'b00, tin_reg[g]};
            tout_s = {2'b00, tout_reg[g]};
            if (sel_reg[g].ok) begin
                if (ctl_reg[g][g].pz) begin
                    // parallel to this edge: outside rejects
                    if (ctl_reg[g][g].qneg) begin
                        sel_n.ok = 1'b0;
                    end
                end else if (ctl_reg[g][g].pneg) begin
                    if (r > tout_s) begin
                        sel_n.ok = 1'b0;
                    end else if (r > tin_s) begin
                        tin_n         = r[F:0];
                        sel_n.in_upd  = 1'b1;
                        sel_n.in_edge = lrc_pkg::edge_id_t'(2'(g));
                    end
                end else begin
                    if (r < tin_s) begin
                        sel_n.ok = 1'b0;
                    end else if (r < tout_s) begin
                        tout_n         = r[F:0];
                        sel_n.out_upd  = 1'b1;
                        sel_n.out_edge = lrc_pkg::edge_id_t'(2'(g));
                    end
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sel_reg[g+1]  <= sel_n;
                tin_reg[g+1]  <= tin_n;
                tout_reg[g+1] <= tout_n;
                geo_reg[g+1]  <= geo_reg[g];
            end
        end

        if (g < 3) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    code_reg[g+1] <= code_reg[g];
                    ctl_reg[g+1]  <= ctl_reg[g];
                end
            end
        end
    end

    assign out_valid = valid_reg[4];
    assign out_sel   = sel_reg[4];
    assign t_in      = tin_reg[4];
    assign t_out     = tout_reg[4];
    assign out_geo   = geo_reg[4];

endmodule

`default_nettype wire

>>> hdl/lrc_point.sv
// ----------------------------------------------------------------------------
// lrc_point
// clipped endpoints: multiply stage, then round, saturate and pack stage
// ----------------------------------------------------------------------------
`default_nettype none

module lrc_point #(
    parameter int COORD_BITS  = 16,
    parameter int T_FRAC_BITS = 16
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         en,
    input  wire logic                         in_valid,
    input  wire lrc_pkg::clip_sel_t           sel,
    input  wire logic [T_FRAC_BITS:0]         t_in,
    input  wire logic [T_FRAC_BITS:0]         t_out,
    input  wire logic signed [COORD_BITS-1:0] sx,
    input  wire logic signed [COORD_BITS-1:0] sy,
    input  wire logic signed [COORD_BITS:0]   dx,
    input  wire logic signed [COORD_BITS:0]   dy,
    input  wire logic signed [COORD_BITS+1:0] edge_pos [4],
    output logic                              out_valid,
    output logic                              accepted,
    output logic signed [COORD_BITS-1:0]      clip_start_x,
    output logic signed [COORD_BITS-1:0]      clip_start_y,
    output logic signed [COORD_BITS-1:0]      clip_end_x,
    output logic signed [COORD_BITS-1:0]      clip_end_y,
    output logic [T_FRAC_BITS:0]              t_enter,
    output logic [T_FRAC_BITS:0]              t_exit
);

    localparam int C  = COORD_BITS;
    localparam int F  = T_FRAC_BITS;
    localparam int VW = C + F + 3;
    localparam logic signed [VW-1:0] CMAX = {{(VW-C+1){1'b0}}, {(C-1){1'b1}}};
    localparam logic signed [VW-1:0] CMIN = {{(VW-C+1){1'b1}}, {(C-1){1'b0}}};
    localparam logic signed [VW-1:0] HALF = {{(VW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};

    function automatic logic [C-1:0] sat_coord(input logic signed [VW-1:0] v);
        logic [C-1:0] res;
        if (v > CMAX) begin
            res = CMAX[C-1:0];
        end else if (v < CMIN) begin
            res = CMIN[C-1:0];
        end else begin
            res = v[C-1:0];
        end
        return res;
    endfunction

    // edge in Q.5 to Q.4, nearest, ties up
    function automatic logic [C-1:0] edge_round(input logic signed [C+1:0] e);
        logic signed [C+2:0] e_ext;
        logic signed [C+2:0] h;
        e_ext = {e[C+1], e};
        h     = (e_ext + 2'sd1) >>> 1;
        return sat_coord({{(VW-C-3){h[C+2]}}, h});
    endfunction

    // start + t * delta, Q.4, nearest, ties up
    function automatic logic [C-1:0] along(input logic signed [C-1:0] s,
                                           input logic signed [VW-1:0] prod);
        logic signed [VW-1:0] s_ext;
        logic signed [VW-1:0] sum;
        s_ext = {{(VW-C){s[C-1]}}, s};
        sum   = (s_ext <<< F) + prod + HALF;
        return sat_coord(sum >>> F);
    endfunction

    // multiply stage
    logic                m_valid_reg, m_ok_reg;
    logic                m_in_upd_reg, m_out_upd_reg, m_in_x_reg, m_out_x_reg;
    logic signed [VW-1:0] m_prod_a_reg, m_prod_b_reg, prod_a_next, prod_b_next;
    logic signed [C-1:0] m_sa_reg, m_sb_reg;
    logic signed [C+1:0] m_ea_reg, m_eb_reg;
    logic signed [C-1:0] m_sx_reg, m_sy_reg, m_ex_reg, m_ey_reg;
    logic [F:0]          m_tin_reg, m_tout_reg;

    logic                in_x, out_x;
    logic signed [F+1:0] tin_s, tout_s;
    logic signed [C:0]   da, db;

    always_comb begin
        in_x   = (sel.in_edge == lrc_pkg::EDGE_LEFT) || (sel.in_edge == lrc_pkg::EDGE_RIGHT);
        out_x  = (sel.out_edge == lrc_pkg::EDGE_LEFT) ||
                 (sel.out_edge == lrc_pkg::EDGE_RIGHT);
        tin_s  = {1'b0, t_in};
        tout_s = {1'b0, t_out};
        // a left/right clip moves along y, a top/bottom clip along x
        da = in_x ? dy : dx;
        db = out_x ? dy : dx;
        prod_a_next = tin_s * da;
        prod_b_next = tout_s * db;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_ok_reg      <= sel.ok && (t_in <= t_out);
            m_in_upd_reg  <= sel.in_upd;
            m_out_upd_reg <= sel.out_upd;
            m_in_x_reg    <= in_x;
            m_out_x_reg   <= out_x;
            m_prod_a_reg  <= prod_a_next;
            m_prod_b_reg  <= prod_b_next;
            m_sa_reg      <= in_x ? sy : sx;
            m_sb_reg      <= out_x ? sy : sx;
            m_ea_reg      <= edge_pos[sel.in_edge];
            m_eb_reg      <= edge_pos[sel.out_edge];
            m_sx_reg      <= sx;
            m_sy_reg      <= sy;
            m_ex_reg      <= sx + dx[C-1:0];
            m_ey_reg      <= sy + dy[C-1:0];
            m_tin_reg     <= t_in;
            m_tout_reg    <= t_out;
        end
    end

    // round stage
    logic         r_valid_reg, r_acc_reg;
    logic [C-1:0] r_ax_reg, r_ay_reg, r_bx_reg, r_by_reg;
    logic [F:0]   r_tin_reg, r_tout_reg;
    logic [C-1:0] ax_next, ay_next, bx_next, by_next;
    logic [C-1:0] a_edge_v, a_along_v, b_edge_v, b_along_v;

    always_comb begin
        a_edge_v  = edge_round(m_ea_reg);
        a_along_v = along(m_sa_reg, m_prod_a_reg);
        b_edge_v  = edge_round(m_eb_reg);
        b_along_v = along(m_sb_reg, m_prod_b_reg);
        ax_next   = m_sx_reg;
        ay_next   = m_sy_reg;
        bx_next   = m_ex_reg;
        by_next   = m_ey_reg;
        if (m_in_upd_reg) begin
            ax_next = m_in_x_reg ? a_edge_v : a_along_v;
            ay_next = m_in_x_reg ? a_along_v : a_edge_v;
        end
        if (m_out_upd_reg) begin
            bx_next = m_out_x_reg ? b_edge_v : b_along_v;
            by_next = m_out_x_reg ? b_along_v : b_edge_v;
        end
        if (!m_ok_reg) begin
            ax_next = '0;
            ay_next = '0;
            bx_next = '0;
            by_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_valid_reg <= 1'b0;
        end else if (en) begin
            r_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_acc_reg  <= m_ok_reg;
            r_ax_reg   <= ax_next;
            r_ay_reg   <= ay_next;
            r_bx_reg   <= bx_next;
            r_by_reg   <= by_next;
            r_tin_reg  <= m_ok_reg ? m_tin_reg : '0;
            r_tout_reg <= m_ok_reg ? m_tout_reg : '0;
        end
    end

    assign out_valid    = r_valid_reg;
    assign accepted     = r_acc_reg;
    assign clip_start_x = r_ax_reg;
    assign clip_start_y = r_ay_reg;
    assign clip_end_x   = r_bx_reg;
    assign clip_end_y   = r_by_reg;
    assign t_enter      = r_tin_reg;
    assign t_exit       = r_tout_reg;

endmodule

`default_nettype wire
